FILE: sv/pidda_pkg.sv
// Shared types and constants for the deadband / anti-windup PID heater controller.
`timescale 1ns / 1ps
`default_nettype none
package pidda_pkg;

	// Field widths
	localparam int TEMP_W  = 16;
	localparam int ERR_W   = 17;
	localparam int GAIN_W  = 24;
	localparam int DB_W    = 15;
	localparam int LIM_W   = 31;
	localparam int INTEG_W = 32;
	localparam int DUTY_W  = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WINDUP_LIMIT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd6;

	// Digit-serial multiplier: signed parallel operand, unsigned serial operand
	localparam int MUL_A_W  = 32;
	localparam int MUL_B_W  = 24;
	localparam int DIGIT_W  = 4;
	localparam int N_DIGITS = MUL_B_W / DIGIT_W;
	localparam int CNT_W    = 3;
	localparam int PSUM_W   = MUL_A_W + DIGIT_W + 1;
	localparam int PH_W     = MUL_A_W + 1;
	localparam int PROD_W   = PH_W + MUL_B_W;

	// Datapath widths
	localparam int INC_W   = 38;
	localparam int ACC_W   = 58;
	localparam int Q_W     = 41;

	localparam int INC_SHIFT   = 4;
	localparam int PD_SHIFT    = 12;
	localparam int ROUND_SHIFT = 17;

	localparam logic signed [PROD_W-1:0] INC_BIAS   = PROD_W'(8);
	localparam logic signed [ACC_W-1:0]  ROUND_BIAS = ACC_W'(65536);

	// Duty snapping thresholds, Q1.15
	localparam logic [DUTY_W-1:0] DUTY_LOW  = 16'd328;
	localparam logic [DUTY_W-1:0] DUTY_HIGH = 16'd32440;
	localparam logic [DUTY_W-1:0] DUTY_FULL = 16'd32768;
	localparam logic [DUTY_W-1:0] DUTY_OFF  = 16'd0;

	// Register file contents
	typedef struct packed {
		logic signed [TEMP_W-1:0] target_temp;
		logic [GAIN_W-1:0]        prop_gain;
		logic [GAIN_W-1:0]        integ_gain;
		logic [GAIN_W-1:0]        deriv_gain;
		logic [DB_W-1:0]          deadband;
		logic [LIM_W-1:0]         windup_limit;
		logic [GAIN_W-1:0]        sample_period;
	} cfg_t;

	// Multiplier status
	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage
`default_nettype wire

FILE: sv/pid_deadband_antiwindup_top.sv
// Top level of the PID heater controller with integration deadband and anti-windup.
//
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   s_tdata[15:0]  measured_temp (signed)
//  m_*       out        m_tvalid/m_tready   m_tdata[15:0]  duty (Q1.15)
//  wr_*      in         wr_en               wr_index[2:0], wr_data[30:0]
//
// One measurement is handled at a time; s_tready is high only while the sequencer is idle.
// Each item makes four passes of the shared digit-serial multiplier between its
// sequencing steps. Reset clears the sequencer, the output valid flag, last_temp and the
// integrator and loads the register defaults. A stalled output holds the block at its
// final step; the next item is taken as soon as the duty register is handed on.
`timescale 1ns / 1ps
`default_nettype none
module pid_deadband_antiwindup_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [pidda_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [pidda_pkg::CFG_DATA_W-1:0] wr_data,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [15:0]                     s_tdata,  // [15:0] measured_temp
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [15:0]                          m_tdata   // [15:0] duty
);
	import pidda_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PREP  = 4'd1;
	localparam logic [3:0] S_WINC  = 4'd2;
	localparam logic [3:0] S_SUM   = 4'd3;
	localparam logic [3:0] S_CLAMP = 4'd4;
	localparam logic [3:0] S_WP    = 4'd5;
	localparam logic [3:0] S_WD    = 4'd6;
	localparam logic [3:0] S_WI    = 4'd7;
	localparam logic [3:0] S_RND   = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	cfg_t                      cfg;
	mul_stat_t                 mul_stat;
	logic                      mul_start;
	logic signed [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	logic signed [PROD_W-1:0]  prod;

	logic [3:0]                st_q;
	logic                      out_valid_q;
	logic [DUTY_W-1:0]         out_data_q;
	logic signed [TEMP_W-1:0]  last_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [TEMP_W-1:0]  meas_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [ERR_W-1:0]   diff_q;
	logic signed [INC_W-1:0]   inc_q;
	logic signed [INC_W-1:0]   sum_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [Q_W-1:0]     q_q;

	logic signed [ERR_W-1:0]   err_c;
	logic signed [ERR_W-1:0]   diff_c;
	logic signed [ERR_W-1:0]   db_c;
	logic signed [ERR_W-1:0]   edb_c;
	logic signed [INC_W-1:0]   lim_c;
	logic signed [Q_W-1:0]     q_low_c;
	logic signed [Q_W-1:0]     q_high_c;
	logic [DUTY_W-1:0]         duty_c;
	logic                      accept;
	logic                      out_load;

	pidda_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	pidda_digit_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.stat   (mul_stat),
		.prod   (prod)
	);

	// error, derivative difference and deadband
	always_comb begin
		err_c  = ERR_W'(cfg.target_temp) - ERR_W'(meas_q);
		diff_c = ERR_W'(meas_q) - ERR_W'(last_q);
		db_c   = $signed({2'b00, cfg.deadband});
		if (err_c > db_c) begin
			edb_c = err_c - db_c;
		end else if (err_c < -db_c) begin
			edb_c = err_c + db_c;
		end else begin
			edb_c = '0;
		end
		lim_c = $signed({{(INC_W - LIM_W){1'b0}}, cfg.windup_limit});
	end

	// duty snapping
	always_comb begin
		q_low_c  = $signed(Q_W'(DUTY_LOW));
		q_high_c = $signed(Q_W'(DUTY_HIGH));
		if (q_q < q_low_c) begin
			duty_c = DUTY_OFF;
		end else if (q_q > q_high_c) begin
			duty_c = DUTY_FULL;
		end else begin
			duty_c = q_q[DUTY_W-1:0];
		end
	end

	// multiplier operand selection per step
	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (st_q)
			S_PREP: begin
				mul_start = 1'b1;
				mul_a     = MUL_A_W'(edb_c);
				mul_b     = cfg.sample_period;
			end
			S_CLAMP: begin
				mul_start = 1'b1;
				mul_a     = MUL_A_W'(err_q);
				mul_b     = cfg.prop_gain;
			end
			S_WP: begin
				mul_start = mul_stat.done;
				mul_a     = MUL_A_W'(diff_q);
				mul_b     = cfg.deriv_gain;
			end
			S_WD: begin
				mul_start = mul_stat.done;
				mul_a     = integ_q;
				mul_b     = cfg.integ_gain;
			end
			default: begin
			end
		endcase
	end

	assign accept   = s_tvalid && (st_q == S_IDLE);
	assign out_load = (st_q == S_OUT) && (!out_valid_q || m_tready);

	// sequencer, controller state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			out_valid_q <= 1'b0;
			last_q      <= '0;
			integ_q     <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (accept) st_q <= S_PREP;
				end
				S_PREP: begin
					last_q <= meas_q;
					st_q   <= S_WINC;
				end
				S_WINC: begin
					if (mul_stat.done) st_q <= S_SUM;
				end
				S_SUM: begin
					st_q <= S_CLAMP;
				end
				S_CLAMP: begin
					if (sum_q > lim_c) begin
						integ_q <= INTEG_W'(lim_c);
					end else if (sum_q < -lim_c) begin
						integ_q <= INTEG_W'(-lim_c);
					end else begin
						integ_q <= INTEG_W'(sum_q);
					end
					st_q <= S_WP;
				end
				S_WP: begin
					if (mul_stat.done) st_q <= S_WD;
				end
				S_WD: begin
					if (mul_stat.done) st_q <= S_WI;
				end
				S_WI: begin
					if (mul_stat.done) st_q <= S_RND;
				end
				S_RND: begin
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) st_q <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			meas_q <= $signed(s_tdata);
		end
		if (st_q == S_PREP) begin
			err_q  <= err_c;
			diff_q <= diff_c;
		end
		if (st_q == S_WINC && mul_stat.done) begin
			inc_q <= INC_W'((prod + INC_BIAS) >>> INC_SHIFT);
		end
		if (st_q == S_SUM) begin
			sum_q <= INC_W'(integ_q) + inc_q;
		end
		if (st_q == S_WP && mul_stat.done) begin
			acc_q <= ACC_W'(prod) <<< PD_SHIFT;
		end
		if (st_q == S_WD && mul_stat.done) begin
			acc_q <= acc_q - (ACC_W'(prod) <<< PD_SHIFT);
		end
		if (st_q == S_WI && mul_stat.done) begin
			acc_q <= acc_q + ACC_W'(prod);
		end
		if (st_q == S_RND) begin
			q_q <= Q_W'((acc_q + ROUND_BIAS) >>> ROUND_SHIFT);
		end
		if (out_load) begin
			out_data_q <= duty_c;
		end
	end

	assign s_tready = (st_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// a new item never meets a multiplier still at work
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !mul_stat.busy)
		else $error("item taken while multiplier busy");

	// a finished product is always picked up by a waiting step
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> (st_q == S_WINC || st_q == S_WP || st_q == S_WD || st_q == S_WI))
		else $error("multiplier result dropped");

	// integrator respects the windup clamp once updated
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_CLAMP) |=> (INC_W'(integ_q) <= lim_c && INC_W'(integ_q) >= -lim_c))
		else $error("integrator beyond windup limit");

	// duty is off, full on, or inside the snapping band
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == DUTY_OFF || m_tdata == DUTY_FULL ||
			(m_tdata >= DUTY_LOW && m_tdata <= DUTY_HIGH)))
		else $error("duty outside snapped range");

endmodule
`default_nettype wire

FILE: sv/pidda_cfg_regs.sv
// Configuration register file of the PID heater controller.
`timescale 1ns / 1ps
`default_nettype none
module pidda_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [pidda_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [pidda_pkg::CFG_DATA_W-1:0] wr_data,
	output pidda_pkg::cfg_t                      cfg
);
	import pidda_pkg::*;

	cfg_t cfg_q;

	// write decode; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_temp   <= '0;
			cfg_q.prop_gain     <= GAIN_W'(3277);
			cfg_q.integ_gain    <= GAIN_W'(13107);
			cfg_q.deriv_gain    <= GAIN_W'(655);
			cfg_q.deadband      <= DB_W'(8);
			cfg_q.windup_limit  <= LIM_W'(327680);
			cfg_q.sample_period <= GAIN_W'(65536);
		end else if (wr_en) begin
			case (wr_index)
				REG_TARGET_TEMP:   cfg_q.target_temp   <= $signed(wr_data[TEMP_W-1:0]);
				REG_PROP_GAIN:     cfg_q.prop_gain     <= wr_data[GAIN_W-1:0];
				REG_INTEG_GAIN:    cfg_q.integ_gain    <= wr_data[GAIN_W-1:0];
				REG_DERIV_GAIN:    cfg_q.deriv_gain    <= wr_data[GAIN_W-1:0];
				REG_DEADBAND:      cfg_q.deadband      <= wr_data[DB_W-1:0];
				REG_WINDUP_LIMIT:  cfg_q.windup_limit  <= wr_data[LIM_W-1:0];
				REG_SAMPLE_PERIOD: cfg_q.sample_period <= wr_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: sv/pidda_digit_mul.sv
// Digit-serial signed-by-unsigned multiplier, one 4-bit digit of the serial operand per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pidda_digit_mul (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [pidda_pkg::MUL_A_W-1:0] a,
	input  wire logic [pidda_pkg::MUL_B_W-1:0]        b,
	output pidda_pkg::mul_stat_t                     stat,
	output logic signed [pidda_pkg::PROD_W-1:0]       prod
);
	import pidda_pkg::*;

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [MUL_A_W-1:0] a_q;
	logic [MUL_B_W-1:0]        b_q;
	logic signed [PH_W-1:0]    ph_q;
	logic [MUL_B_W-1:0]        lo_q;
	logic signed [PSUM_W-1:0]  pp;
	logic signed [PSUM_W-1:0]  psum;

	// partial product of the current digit plus the running high part
	always_comb begin
		pp   = a_q * $signed({1'b0, b_q[DIGIT_W-1:0]});
		psum = pp + PSUM_W'(ph_q);
	end

	// digit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_DIGITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// operand and product shift registers; low digits retire into lo_q
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			a_q  <= a;
			b_q  <= b;
			ph_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			b_q  <= b_q >> DIGIT_W;
			ph_q <= psum[PSUM_W-1:DIGIT_W];
			lo_q <= {psum[DIGIT_W-1:0], lo_q[MUL_B_W-1:DIGIT_W]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = $signed({ph_q, lo_q});

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the PID heater controller: predicted duties against the stream output.
`timescale 1ns / 1ps

import pidda_pkg::*;

// Keeps a copy of the controller's registers and state, predicts the duty for each
// measurement taken and checks the duties that come out, in order.
class duty_tracker;
	logic signed [TEMP_W-1:0]  target_temp;
	logic [GAIN_W-1:0]         prop_gain;
	logic [GAIN_W-1:0]         integ_gain;
	logic [GAIN_W-1:0]         deriv_gain;
	logic [DB_W-1:0]           deadband;
	logic [LIM_W-1:0]          windup_limit;
	logic [GAIN_W-1:0]         sample_period;
	logic signed [TEMP_W-1:0]  last_temp;
	logic signed [INTEG_W-1:0] integrator;
	logic [DUTY_W-1:0]         duty_due[$];
	int                        errors;
	int                        checked;
	int                        taken;

	function new();
		target_temp   = '0;
		prop_gain     = 24'd3277;
		integ_gain    = 24'd13107;
		deriv_gain    = 24'd655;
		deadband      = 15'd8;
		windup_limit  = 31'd327680;
		sample_period = 24'd65536;
		last_temp     = '0;
		integrator    = '0;
		errors        = 0;
		checked       = 0;
		taken         = 0;
	endfunction

	// Register write; only the low bits of each register are kept
	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_TARGET_TEMP:   target_temp   = data[TEMP_W-1:0];
			REG_PROP_GAIN:     prop_gain     = data[GAIN_W-1:0];
			REG_INTEG_GAIN:    integ_gain    = data[GAIN_W-1:0];
			REG_DERIV_GAIN:    deriv_gain    = data[GAIN_W-1:0];
			REG_DEADBAND:      deadband      = data[DB_W-1:0];
			REG_WINDUP_LIMIT:  windup_limit  = data[LIM_W-1:0];
			REG_SAMPLE_PERIOD: sample_period = data[GAIN_W-1:0];
			default: ;
		endcase
	endfunction

	// One control step: deadband integration with clamp, derivative on measurement
	function logic [DUTY_W-1:0] predict_duty(logic signed [TEMP_W-1:0] meas);
		longint err;
		longint band;
		longint lim;
		longint e_db;
		longint sum;
		longint diff;
		longint acc;
		longint q;
		err  = longint'(target_temp) - longint'(meas);
		band = longint'(deadband);
		lim  = longint'(windup_limit);
		e_db = 0;
		if (err < -band)
			e_db = err + band;
		else if (err > band)
			e_db = err - band;

		// increment rounded to nearest, clamp applied every step
		sum = longint'(integrator) + ((e_db * longint'(sample_period) + 8) >>> INC_SHIFT);
		if (sum > lim)
			sum = lim;
		else if (sum < -lim)
			sum = -lim;
		integrator = sum[INTEG_W-1:0];

		diff      = longint'(meas) - longint'(last_temp);
		last_temp = meas;

		acc = ((err * longint'(prop_gain) - diff * longint'(deriv_gain)) <<< PD_SHIFT)
			+ longint'(integrator) * longint'(integ_gain);
		q = (acc + 65536) >>> ROUND_SHIFT;

		// snap near-off and near-full duties
		if (q < longint'(DUTY_LOW))
			return DUTY_OFF;
		else if (q > longint'(DUTY_HIGH))
			return DUTY_FULL;
		return q[DUTY_W-1:0];
	endfunction

	function void take_measurement(logic signed [TEMP_W-1:0] meas);
		duty_due.push_back(predict_duty(meas));
		taken++;
	endfunction

	function void check_duty(logic [DUTY_W-1:0] actual);
		logic [DUTY_W-1:0] want;
		if (duty_due.size() == 0) begin
			errors++;
			$display("%0t: duty %0d arrived with no measurement outstanding", $time, actual);
			return;
		end
		want = duty_due.pop_front();
		checked++;
		if (actual !== want) begin
			errors++;
			$display("%0t: duty mismatch, expected %0d, actual %0d", $time, want, actual);
		end
	endfunction
endclass

module testbench;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [15:0]           s_tdata;   // [15:0] measured_temp
	logic                  m_tvalid;
	logic                  m_tready;
	logic [15:0]           m_tdata;   // [15:0] duty

	duty_tracker           tracker;
	bit                    calm;
	int                    gap_pct;
	int                    stall_pct;
	int                    settings;
	logic signed [15:0]    prev_meas;

	pid_deadband_antiwindup_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Clock, 12 ns period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Register write, one cycle of wr_en
	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		wr_en    = 1'b1;
		wr_index = idx;
		wr_data  = data;
		@(posedge clk);
		tracker.write_reg(idx, data);
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	// Drop the input stream and wait for every outstanding duty, then a few spare cycles
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (tracker.duty_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		settings++;
	endtask

	// One measurement, with an optional gap in front of it
	task automatic send_meas(logic signed [15:0] meas);
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = meas;
		do
			@(posedge clk);
		while (!s_tready);
		tracker.take_measurement(meas);
		prev_meas = meas;
	endtask

	// New register set: plausible loop tuning, or raw random patterns
	task automatic random_settings(bit wild);
		if (wild) begin
			set_reg(REG_TARGET_TEMP,   CFG_DATA_W'($urandom));
			set_reg(REG_PROP_GAIN,     CFG_DATA_W'($urandom));
			set_reg(REG_INTEG_GAIN,    CFG_DATA_W'($urandom));
			set_reg(REG_DERIV_GAIN,    CFG_DATA_W'($urandom));
			set_reg(REG_DEADBAND,      CFG_DATA_W'($urandom));
			set_reg(REG_WINDUP_LIMIT,  CFG_DATA_W'($urandom));
			set_reg(REG_SAMPLE_PERIOD, CFG_DATA_W'($urandom));
		end else begin
			set_reg(REG_TARGET_TEMP,   CFG_DATA_W'(int'($urandom_range(0, 8000)) - 2000));
			set_reg(REG_PROP_GAIN,     CFG_DATA_W'($urandom_range(0, 40000)));
			set_reg(REG_INTEG_GAIN,    CFG_DATA_W'($urandom_range(0, 60000)));
			set_reg(REG_DERIV_GAIN,    CFG_DATA_W'($urandom_range(0, 8000)));
			set_reg(REG_DEADBAND,      CFG_DATA_W'($urandom_range(0, 64)));
			set_reg(REG_WINDUP_LIMIT,  CFG_DATA_W'($urandom_range(0, 1 << 20)));
			set_reg(REG_SAMPLE_PERIOD, CFG_DATA_W'($urandom_range(1, 1 << 18)));
		end
		// index past the register list must be ignored
		set_reg(REG_UNUSED, CFG_DATA_W'($urandom));
	endtask

	// Random measurements: slow drift, values around the setpoint, or anything
	task automatic run_meas(int count);
		int                 pick;
		logic signed [15:0] meas;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				meas = 16'(int'(prev_meas) + int'($urandom_range(0, 40)) - 20);
			else if (pick < 75)
				meas = 16'(int'(tracker.target_temp) + int'($urandom_range(0, 1200)) - 600);
			else
				meas = 16'($urandom);
			send_meas(meas);
		end
	endtask

	// Output side: ready held or dropped in random bursts
	initial begin
		int hold;
		hold     = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm)
				m_tready = 1'b1;
			else if (hold > 0)
				hold--;
			else if ($urandom_range(0, 99) < stall_pct) begin
				m_tready = 1'b0;
				hold     = $urandom_range(1, 14) - 1;
			end else begin
				m_tready = 1'b1;
				hold     = $urandom_range(0, 10);
			end
		end
	end

	// Duty check at each output handshake
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_duty(m_tdata);
	end

	// Stimulus
	initial begin
		int waited;
		tracker   = new();
		calm      = 1'b0;
		gap_pct   = 25;
		stall_pct = 25;
		settings  = 1;
		prev_meas = '0;
		arst_n    = 1'b0;
		wr_en     = 1'b0;
		wr_index  = '0;
		wr_data   = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults: field extremes, first sample derivative, deadband edges
		send_meas(16'sd0);
		send_meas(16'sd32767);
		send_meas(-16'sd32768);
		send_meas(16'sd32767);
		send_meas(16'sd8);
		send_meas(-16'sd8);
		send_meas(16'sd9);
		send_meas(-16'sd9);
		send_meas(-16'sd1);
		send_meas(16'sd1);

		// zero period and zero windup limit: integrator pinned at 0
		settle();
		set_reg(REG_SAMPLE_PERIOD, '0);
		set_reg(REG_WINDUP_LIMIT, '0);
		send_meas(-16'sd32768);
		send_meas(16'sd32767);
		send_meas(16'sd0);

		// zero period with full limit: no increment, clamp still applied
		settle();
		set_reg(REG_WINDUP_LIMIT, 31'h7FFF_FFFF);
		send_meas(-16'sd32768);
		send_meas(16'sd100);

		// target at its most negative, other registers but the windup limit all ones, upper bits dropped
		settle();
		set_reg(REG_TARGET_TEMP,   31'h7FFF_8000);
		set_reg(REG_PROP_GAIN,     31'h7FFF_FFFF);
		set_reg(REG_INTEG_GAIN,    31'h7FFF_FFFF);
		set_reg(REG_DERIV_GAIN,    31'h7FFF_FFFF);
		set_reg(REG_DEADBAND,      31'h7FFF_FFFF);
		set_reg(REG_SAMPLE_PERIOD, 31'h7FFF_FFFF);
		set_reg(REG_UNUSED,        31'h7FFF_FFFF);
		send_meas(16'sd32767);
		send_meas(-16'sd32768);
		send_meas(16'sd32767);
		send_meas(16'sd0);

		// top setpoint, no deadband
		settle();
		set_reg(REG_TARGET_TEMP, 31'h0000_7FFF);
		set_reg(REG_DEADBAND, '0);
		send_meas(-16'sd32768);
		send_meas(-16'sd32768);
		send_meas(16'sd32767);

		// random phases with varying tuning and back-pressure
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			random_settings(ph == 2 || ph == 4);
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 20;
				default: gap_pct = 50;
			endcase
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 20;
				default: stall_pct = 50;
			endcase
			run_meas(100);
		end

		// closing stretch at full rate
		settle();
		random_settings(1'b0);
		calm = 1'b1;
		run_meas(50);

		// drain, bounded
		@(negedge clk);
		s_tvalid = 1'b0;
		waited   = 0;
		while (tracker.duty_due.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (tracker.duty_due.size() != 0) begin
			tracker.errors++;
			$display("%0t: %0d duties never arrived", $time, tracker.duty_due.size());
		end

		$display("Run covered %0d measurements under %0d register settings, %0d duties compared.",
			tracker.taken, settings, tracker.checked);
		$display("Mismatches and stray duties: %0d", tracker.errors);
		if (tracker.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Overall time limit
	initial begin
		#5ms;
		$display("Time limit reached with %0d duties outstanding", tracker.duty_due.size());
		$display("FAIL");
		$finish;
	end
endmodule

FILE: filelist.f
sv/pidda_pkg.sv
sv/pidda_cfg_regs.sv
sv/pidda_digit_mul.sv
sv/pid_deadband_antiwindup_top.sv
verif/testbench.sv
